// ----- sv/pmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsd_pkg
// Shared widths, limits and types for the partition maximum-sum block.
// ----------------------------------------------------------------------------
package pmsd_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 26;
    localparam int CNT_W      = 5;
    localparam int PROD_W     = VAL_W + CNT_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(3);

    // Running partial result that walks down the chain of cells.
    typedef struct packed {
        logic                    valid;
        logic [CNT_W-1:0]        j;
        logic signed [VAL_W-1:0] pm;
        logic signed [SUM_W-1:0] best;
    } tok_t;

    // Shift strobes for the stored values and prefix totals.
    typedef struct packed {
        logic val_en;
        logic sum_en;
    } shift_t;

endpackage

// ----- sv/pmsd_cell.sv -----
// ----------------------------------------------------------------------------
// pmsd_cell
// One position of the window: holds an element and a prefix total, and
// folds one piece-length candidate into the running result passing by.
// ----------------------------------------------------------------------------
module pmsd_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pmsd_pkg::shift_t                  shift,
    input  logic [pmsd_pkg::CNT_W-1:0]        lim,
    input  logic signed [pmsd_pkg::VAL_W-1:0] val_in,
    output logic signed [pmsd_pkg::VAL_W-1:0] val_out,
    input  logic signed [pmsd_pkg::SUM_W-1:0] sum_in,
    output logic signed [pmsd_pkg::SUM_W-1:0] sum_out,
    input  pmsd_pkg::tok_t                    tok_in,
    output pmsd_pkg::tok_t                    tok_out
);
    import pmsd_pkg::*;

    logic signed [VAL_W-1:0]  val_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    tok_t                     tok_reg;
    tok_t                     tok_next;
    logic                     first;
    logic                     active;
    logic signed [VAL_W-1:0]  pm;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W:0]    total;
    logic signed [SUM_W-1:0]  cand;

    always_comb begin
        first  = (tok_in.j == CNT_W'(1));
        active = tok_in.valid && (tok_in.j <= lim);
        pm     = (first || (val_reg > tok_in.pm)) ? val_reg : tok_in.pm;
        prod   = PROD_W'($signed({1'b0, tok_in.j}) * pm);
        total  = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(prod);
        // Saturate the candidate total at the result range.
        if (total > (SUM_W+1)'(SUM_MAX)) begin
            cand = SUM_MAX;
        end else if (total < (SUM_W+1)'(SUM_MIN)) begin
            cand = SUM_MIN;
        end else begin
            cand = total[SUM_W-1:0];
        end
        tok_next.valid = tok_in.valid;
        tok_next.j     = tok_in.j + CNT_W'(1);
        tok_next.pm    = pm;
        tok_next.best  = (active && (first || (cand > tok_in.best))) ? cand : tok_in.best;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            sum_reg       <= '0;
        end else begin
            tok_reg.valid <= tok_next.valid;
            if (shift.sum_en) begin
                sum_reg <= sum_in;
            end
        end
        tok_reg.j    <= tok_next.j;
        tok_reg.pm   <= tok_next.pm;
        tok_reg.best <= tok_next.best;
        if (shift.val_en) begin
            val_reg <= val_in;
        end
    end

    assign val_out = val_reg;
    assign sum_out = sum_reg;
    assign tok_out = tok_reg;

endmodule

// ----- sv/partition_max_sum_dp_top.sv -----
// ----------------------------------------------------------------------------
// partition_max_sum_dp_top
// Partition-for-maximum-sum dynamic program over a stream of elements.
// ----------------------------------------------------------------------------
// Usage:
//   Elements enter on the s_ channel one beat at a time; s_tlast marks the
//   final element of an array. Every input beat yields exactly one beat on
//   the m_ channel carrying the best partition total of the prefix so far,
//   saturated to 26 bits; m_tlast echoes s_tlast and marks the full answer.
//   The cfg_ channel writes the window length (pieces of at most that many
//   elements, 0 acts as 1, above 16 acts as 16); it is always ready. The user
//   must see that it is written only while the block is idle; the block does not enforce it.
// Timing:
//   A row of 16 cells holds the newest elements and prefix totals. After a
//   beat is accepted a running result walks through all 16 cells, one cell
//   per cycle, and is then registered in a holding register and in the
//   output register, which drives m_tvalid. One element is processed at a
//   time; a new element is not taken while one is still in the cells.
// Reset and stalls:
//   aresetn (synchronous, active low) empties the block and sets the window
//   length to 3. A stalled receiver holds the finished result in a holding
//   register while the output beat waits; the next input beat is accepted
//   once that result has moved into the output register.
// ----------------------------------------------------------------------------
module partition_max_sum_dp_top (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: element_value [15:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    // m_tdata: best_sum [25:0], zero [31:26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // cfg_data: window_length [4:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import pmsd_pkg::*;

    logic [CNT_W-1:0]        window_reg;
    logic [CNT_W-1:0]        items_reg;
    logic [CNT_W-1:0]        lim_reg;
    logic [CNT_W-1:0]        lim_next;
    logic [CNT_W-1:0]        wl_eff;
    logic                    last_reg;
    logic                    start_reg;
    logic                    busy_reg;
    logic                    done_valid_reg;
    logic signed [SUM_W-1:0] done_best_reg;
    logic                    done_last_reg;
    logic                    m_valid_reg;
    logic signed [SUM_W-1:0] m_best_reg;
    logic                    m_last_reg;
    logic                    accept;
    logic                    commit;
    shift_t                  shift;

    logic signed [VAL_W-1:0] val_chain [MAX_WINDOW+1];
    logic signed [SUM_W-1:0] sum_chain [MAX_WINDOW+1];
    tok_t                    tok_chain [MAX_WINDOW+1];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg && !done_valid_reg;
    assign accept    = s_tvalid && s_tready;
    // A finished result moves to the output register once that is free.
    assign commit    = done_valid_reg && (!m_valid_reg || m_tready);

    assign shift.val_en = accept;
    assign shift.sum_en = commit;

    // Effective piece limit: the window length clamped to 1..MAX_WINDOW and
    // to the number of elements of this array seen so far, this one included.
    always_comb begin
        if (window_reg == '0) begin
            wl_eff = CNT_W'(1);
        end else if (window_reg > CNT_W'(MAX_WINDOW)) begin
            wl_eff = CNT_W'(MAX_WINDOW);
        end else begin
            wl_eff = window_reg;
        end
        lim_next = (wl_eff > items_reg + CNT_W'(1)) ? items_reg + CNT_W'(1) : wl_eff;
    end

    // The newest element enters the first cell; the newest total too, which
    // is the empty-prefix zero when an array has just ended.
    assign val_chain[0] = $signed(s_tdata);
    assign sum_chain[0] = done_last_reg ? SUM_W'(0) : done_best_reg;

    always_comb begin
        tok_chain[0].valid = start_reg;
        tok_chain[0].j     = CNT_W'(1);
        tok_chain[0].pm    = '0;
        tok_chain[0].best  = '0;
    end

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        pmsd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (shift),
            .lim     (lim_reg),
            .val_in  (val_chain[k]),
            .val_out (val_chain[k+1]),
            .sum_in  (sum_chain[k]),
            .sum_out (sum_chain[k+1]),
            .tok_in  (tok_chain[k]),
            .tok_out (tok_chain[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= WINDOW_RESET;
            items_reg      <= '0;
            start_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            done_valid_reg <= 1'b0;
            done_last_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_data;
            end
            start_reg <= accept;
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (tok_chain[MAX_WINDOW].valid) begin
                busy_reg <= 1'b0;
            end
            if (tok_chain[MAX_WINDOW].valid) begin
                done_valid_reg <= 1'b1;
                done_last_reg  <= last_reg;
            end else if (commit) begin
                done_valid_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
                if (done_last_reg) begin
                    items_reg <= '0;
                end else if (items_reg < CNT_W'(MAX_WINDOW)) begin
                    items_reg <= items_reg + CNT_W'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            lim_reg  <= lim_next;
            last_reg <= s_tlast;
        end
        if (tok_chain[MAX_WINDOW].valid) begin
            done_best_reg <= tok_chain[MAX_WINDOW].best;
        end
        if (commit) begin
            m_best_reg <= done_best_reg;
            m_last_reg <= done_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(32-SUM_W){1'b0}}, m_best_reg};
    assign m_tlast  = m_last_reg;

endmodule
